/* rtl/core/vde_pkg.sv */
// Package for the vector distance engine: metric codes, finish-unit states
// and lane/accumulator constants. No dependencies.
package vde_pkg;

  typedef enum logic [1:0] {
    METRIC_L2  = 2'd0,
    METRIC_IP  = 2'd1,
    METRIC_COS = 2'd2,
    METRIC_L1  = 2'd3
  } metric_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_MUL,
    FS_SQRT,
    FS_DIV,
    FS_DONE
  } fin_state_t;

  localparam int LANES         = 4;
  localparam int ELEMENT_WIDTH = 16;
  localparam int ACC_WIDTH     = 48;
  localparam int FRAC_BITS     = 12;
  localparam int OUT_WIDTH     = 48;
  localparam int COS_ONE_SHIFT = 30;

endpackage

/* rtl/core/vector_distance_engine.sv */
// Vector distance engine top level: four lanes, a merge-and-accumulate stage
// and a cosine finish unit. Depends on vde_pkg, vde_lane and vde_finish.
// A non-cosine result is registered in the cycle after its last word; a
// cosine result passes multiply, square root and divide (early exit at one).
// Throughput: one word per cycle, except during the cosine finish or an output stall.
// Reset clears the metric, the accumulators and the output valid flag.
module vector_distance_engine (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [15:0] a_lane0, a_lane1, a_lane2, a_lane3,
  input  logic signed [15:0] b_lane0, b_lane1, b_lane2, b_lane3,
  input  logic [2:0] valid_lanes,
  input  logic last,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [47:0] distance,
  output logic degenerate
);
  import vde_pkg::*;

  localparam int EW = ELEMENT_WIDTH;
  localparam int TW = 2*EW + 2 + $clog2(LANES+1);

  metric_t metric;
  logic signed [EW-1:0] av [LANES];
  logic signed [EW-1:0] bv [LANES];
  logic signed [2*EW+1:0] mt [LANES];
  logic [2*EW-1:0] nat [LANES], nbt [LANES];
  logic signed [ACC_WIDTH-1:0] main_sum, norm_a_sum, norm_b_sum;
  logic signed [ACC_WIDTH-1:0] main_next, na_next, nb_next;
  logic signed [TW-1:0] dm, da, db;
  logic busy, fin_start, fin_done, accept;
  logic signed [ACC_WIDTH:0] cos;

  assign av = '{a_lane0, a_lane1, a_lane2, a_lane3};
  assign bv = '{b_lane0, b_lane1, b_lane2, b_lane3};

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vde_lane #(.EW(EW)) u_lane (
      .a(av[i]), .b(bv[i]), .en(3'(i) < valid_lanes), .metric(metric),
      .main_term(mt[i]), .na_term(nat[i]), .nb_term(nbt[i])
    );
  end

  function automatic logic signed [ACC_WIDTH-1:0] sat(
    input logic signed [ACC_WIDTH-1:0] acc, input logic signed [TW-1:0] d);
    logic signed [ACC_WIDTH+TW:0] s;
    logic signed [ACC_WIDTH+TW:0] mx;
    begin
      s  = (ACC_WIDTH+TW+1)'(acc) + (ACC_WIDTH+TW+1)'(d);
      mx = (ACC_WIDTH+TW+1)'({1'b0, {(ACC_WIDTH-1){1'b1}}});
      if (s > mx) sat = mx[ACC_WIDTH-1:0];
      else if (s < -mx - 1) sat = {1'b1, {(ACC_WIDTH-1){1'b0}}};
      else sat = s[ACC_WIDTH-1:0];
    end
  endfunction

  always_comb begin
    dm = '0; da = '0; db = '0;
    for (int i = 0; i < LANES; i++) begin
      dm = dm + TW'(mt[i]);
      da = da + TW'({1'b0, nat[i]});
      db = db + TW'({1'b0, nbt[i]});
    end
    main_next = sat(main_sum, dm);
    na_next   = sat(norm_a_sum, da);
    nb_next   = sat(norm_b_sum, db);
  end

  assign in_stall  = busy || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign fin_start = accept && last && metric == METRIC_COS
                     && na_next > 0 && nb_next > 0;

  vde_finish #(.AW(ACC_WIDTH)) u_fin (
    .clk(clk), .rst(rst), .start(fin_start), .dot(main_next),
    .na(na_next), .nb(nb_next), .done(fin_done), .cos(cos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      metric <= METRIC_L2;
      main_sum <= '0; norm_a_sum <= '0; norm_b_sum <= '0;
      busy <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (cfg_we) metric <= metric_t'(cfg_data);
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (accept) begin
        if (last) begin
          main_sum <= '0; norm_a_sum <= '0; norm_b_sum <= '0;
          if (fin_start) begin
            busy <= 1'b1;
          end else begin
            out_valid  <= 1'b1;
            degenerate <= metric == METRIC_COS;
            distance   <= (metric == METRIC_COS) ? '0 : 48'(main_next);
          end
        end else begin
          main_sum <= main_next; norm_a_sum <= na_next; norm_b_sum <= nb_next;
        end
      end
      if (fin_done) begin
        busy <= 1'b0; out_valid <= 1'b1; degenerate <= 1'b0;
        distance <= 48'(cos);
      end
    end
  end

endmodule

/* rtl/core/vde_lane.sv */
// One lane of the vector distance engine: main term and norm terms of one
// element pair. Depends on vde_pkg.
module vde_lane #(
  parameter int EW = 16
) (
  input  logic signed [EW-1:0]     a,
  input  logic signed [EW-1:0]     b,
  input  logic                     en,
  input  vde_pkg::metric_t         metric,
  output logic signed [2*EW+1:0]   main_term,
  output logic        [2*EW-1:0]   na_term,
  output logic        [2*EW-1:0]   nb_term
);
  import vde_pkg::*;

  logic signed [EW:0]     d;
  logic        [EW:0]     dabs;
  logic signed [2*EW+1:0] m;

  always_comb begin
    d    = (EW+1)'(a) - (EW+1)'(b);
    dabs = d[EW] ? (EW+1)'(-d) : (EW+1)'(d);
    case (metric)
      METRIC_L2: m = (2*EW+2)'(d * d);
      METRIC_L1: m = (2*EW+2)'({1'b0, dabs}) <<< FRAC_BITS;
      default:   m = (2*EW+2)'(a * b);
    endcase
    main_term = en ? m : '0;
    na_term   = en ? $unsigned((2*EW)'(a * a)) : '0;
    nb_term   = en ? $unsigned((2*EW)'(b * b)) : '0;
  end

endmodule

/* rtl/core/vde_finish.sv */
// Cosine finish unit: multiplies the norms, takes an integer square root and
// divides the dot product bit-serially; no new start until done. Depends on vde_pkg.
module vde_finish #(
  parameter int AW = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [AW-1:0] dot,
  input  logic        [AW-1:0] na,
  input  logic        [AW-1:0] nb,
  output logic                 done,
  output logic signed [AW:0]   cos
);
  import vde_pkg::*;

  localparam int PW = 2*AW;
  localparam int CW = $clog2(PW+1);
  localparam int NW = AW + COS_ONE_SHIFT;

  fin_state_t state, state_next;
  logic [PW-1:0] prod, rem;
  logic [AW-1:0] root, bmul, mag;
  logic [AW:0]   divr;
  logic [NW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [PW+1:0] trial;
  logic [AW:0]   dtrial;

  always_comb begin
    state_next = state;
    done = 1'b0;
    case (state)
      FS_IDLE: if (start) state_next = FS_MUL;
      FS_MUL:  if (cnt == CW'(AW-1)) state_next = FS_SQRT;
      FS_SQRT: if (cnt == CW'(AW-1)) state_next = FS_DIV;
      FS_DIV:  if (cnt == CW'(NW-1) || mag >= root) state_next = FS_DONE;
      FS_DONE: begin
        done = 1'b1;
        state_next = FS_IDLE;
      end
      default: state_next = FS_IDLE;
    endcase
    trial  = {2'b0, rem} - ((PW+2)'({root, 2'b01}) << (2*(AW-1-32'(cnt))));
    dtrial = {divr[AW-1:0], quo[NW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      FS_IDLE: begin
        cnt  <= '0;
        neg  <= dot[AW-1];
        mag  <= dot[AW-1] ? AW'(-dot) : AW'(dot);
        prod <= '0;
        bmul <= nb;
        rem  <= {{AW{1'b0}}, na};
        root <= '0;
      end
      FS_MUL: begin
        if (bmul[AW-1-cnt[CW-2:0]]) begin
          prod <= (prod << 1) + PW'(rem[AW-1:0]);
        end else begin
          prod <= prod << 1;
        end
        cnt <= (cnt == CW'(AW-1)) ? '0 : cnt + 1'b1;
        if (cnt == CW'(AW-1)) begin
          rem <= bmul[0] ? (prod << 1) + PW'(rem[AW-1:0]) : prod << 1;
        end
      end
      FS_SQRT: begin
        if (!trial[PW+1] && trial[PW:0] < (PW+1)'(rem) + 1) begin
          rem  <= trial[PW-1:0];
          root <= {root[AW-2:0], 1'b1};
        end else begin
          root <= {root[AW-2:0], 1'b0};
        end
        cnt <= (cnt == CW'(AW-1)) ? '0 : cnt + 1'b1;
        if (cnt == CW'(AW-1)) begin
          quo  <= {mag, {COS_ONE_SHIFT{1'b0}}};
          divr <= '0;
        end
      end
      FS_DIV: begin
        cnt <= cnt + 1'b1;
        if (dtrial >= {1'b0, root}) begin
          divr <= dtrial - {1'b0, root};
          quo  <= {quo[NW-2:0], 1'b1};
        end else begin
          divr <= dtrial;
          quo  <= {quo[NW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  logic [AW:0] qmag;
  always_comb begin
    qmag = (mag >= root) ? (AW+1)'(64'd1 << COS_ONE_SHIFT) : (AW+1)'(quo);
    cos  = neg ? -$signed(qmag) : $signed(qmag);
  end

endmodule
